[design/mbrms_pkg.sv]
// ----------------------------------------------------------------------------
// mbrms_pkg: shared constants and types for the per-channel block RMS unit
// Accumulator width, configuration register map, register reset values, queue depth.
// ----------------------------------------------------------------------------
package mbrms_pkg;

  // Sum-of-squares accumulator width; saturates at all ones.
  localparam int unsigned SUM_W = 48;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CH_CFG_W   = 4;
  localparam int unsigned FRM_CFG_W  = 17;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CH_CFG_W-1:0]  CH_CFG_RESET  = 4'd8;
  localparam logic [FRM_CFG_W-1:0] FRM_CFG_RESET = 17'd20480;

  // Entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT    = 1'b0,
    REG_FRAMES_PER_BLOCK = 1'b1
  } cfg_reg_e;

endpackage

[design/mbrms_queue.sv]
// ----------------------------------------------------------------------------
// mbrms_queue: small register queue between front and back
// Push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module mbrms_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[design/mbrms_front.sv]
// ----------------------------------------------------------------------------
// mbrms_front: sample intake and per-channel sum of squares
// Tracks channel and frame position, squares each sample, accumulates with
// saturation, and at block end hands one sum per channel to the queue.
// ----------------------------------------------------------------------------
module mbrms_front #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_FRAMES   = 65536,
  parameter int unsigned SAMPLE_BITS  = 16,
  localparam int unsigned CH_W   = $clog2(MAX_CHANNELS + 1),
  localparam int unsigned POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned FRM_W  = $clog2(MAX_FRAMES + 1),
  localparam int unsigned ITEM_W = mbrms_pkg::SUM_W + POS_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          full_o,
  input  logic [CH_W-1:0]               nch_i,
  input  logic [FRM_W-1:0]              nfr_i,
  output logic                          q_push_o,
  output logic [ITEM_W-1:0]             q_data_o,
  input  logic                          q_full_i
);

  localparam int unsigned SUM_W = mbrms_pkg::SUM_W;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SQ_W  = 2 * SB - 1;

  // Intake stage
  logic [POS_W-1:0] pos_q;
  logic [FRM_W-1:0] frm_q;
  logic             accept;
  logic [SB-1:0]    raw, mag;
  logic [2*SB-1:0]  prod;
  logic [CH_W-1:0]  pos_inc;
  logic [FRM_W-1:0] frm_inc;
  logic             frame_end, block_end;

  // Accumulate stage
  logic             sq_valid_q, sq_end_q;
  logic [SQ_W-1:0]  sq_q;
  logic [POS_W-1:0] sq_pos_q;
  logic [SUM_W-1:0] sums_q [MAX_CHANNELS];
  logic [POS_W-1:0] rd_idx;
  logic [SUM_W-1:0] rd_sum, sat_sum;
  logic [SUM_W:0]   acc;

  // Drain
  logic             drain_q;
  logic [POS_W-1:0] drain_cnt_q;
  logic             drain_last, drain_beat;

  assign full_o = drain_q || (sq_valid_q && sq_end_q);
  assign accept = push_i && !full_o;

  assign raw  = sample_i;
  assign mag  = raw[SB-1] ? (~raw + SB'(1)) : raw;
  assign prod = (2*SB)'(mag) * (2*SB)'(mag);

  assign pos_inc   = CH_W'(pos_q) + CH_W'(1);
  assign frm_inc   = frm_q + FRM_W'(1);
  assign frame_end = !(pos_inc < nch_i);
  assign block_end = frame_end && (frm_inc >= nfr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      frm_q      <= '0;
      sq_valid_q <= 1'b0;
      sq_end_q   <= 1'b0;
      sq_pos_q   <= '0;
    end else begin
      sq_valid_q <= accept;
      if (accept) begin
        sq_pos_q <= pos_q;
        sq_end_q <= block_end;
        if (!frame_end) begin
          pos_q <= pos_inc[POS_W-1:0];
        end else begin
          pos_q <= '0;
          frm_q <= block_end ? '0 : frm_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  // One read port shared by accumulate and drain; they never overlap.
  assign rd_idx  = drain_q ? drain_cnt_q : sq_pos_q;
  assign rd_sum  = sums_q[rd_idx];
  assign acc     = {1'b0, rd_sum} + (SUM_W+1)'(sq_q);
  assign sat_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];

  assign drain_last = ((CH_W'(drain_cnt_q) + CH_W'(1)) == nch_i);
  assign drain_beat = drain_q && !q_full_i;
  assign q_push_o   = drain_beat;
  assign q_data_o   = {rd_sum, drain_cnt_q, drain_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        sums_q[i] <= '0;
      end
    end else if (drain_beat && drain_last) begin
      // Clear every channel, including ones beyond the current count.
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        sums_q[i] <= '0;
      end
    end else if (sq_valid_q && !drain_q) begin
      sums_q[sq_pos_q] <= sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      drain_cnt_q <= '0;
    end else if (sq_valid_q && sq_end_q) begin
      drain_q     <= 1'b1;
      drain_cnt_q <= '0;
    end else if (drain_beat) begin
      if (drain_last) begin
        drain_q <= 1'b0;
      end
      drain_cnt_q <= drain_cnt_q + POS_W'(1);
    end
  end

  a_no_accept_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !drain_q && !(sq_valid_q && sq_end_q))
    else $error("sample taken while block end in progress");

  a_end_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid_q && sq_end_q) |=> (drain_q && drain_cnt_q == '0))
    else $error("block end did not start the drain");

  a_clear_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_beat && drain_last) |=> (!drain_q && sums_q[0] == '0))
    else $error("sums not cleared after last beat of drain");

endmodule

[design/mbrms_back.sv]
// ----------------------------------------------------------------------------
// mbrms_back: mean and root per channel
// Restoring divide of the channel sum by the frame count, one quotient bit a
// cycle, then a digit-by-digit square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module mbrms_back #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_FRAMES   = 65536,
  parameter int unsigned SAMPLE_BITS  = 16,
  localparam int unsigned POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned FRM_W  = $clog2(MAX_FRAMES + 1),
  localparam int unsigned ITEM_W = mbrms_pkg::SUM_W + POS_W + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ITEM_W-1:0]      q_data_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic [FRM_W-1:0]       nfr_i,
  output logic [SAMPLE_BITS-1:0] rms_value_o,
  output logic [POS_W-1:0]       channel_index_o,
  output logic                   last_of_block_o,
  output logic                   empty_o,
  input  logic                   pop_i
);

  localparam int unsigned SUM_W  = mbrms_pkg::SUM_W;
  localparam int unsigned ROOT_W = SUM_W / 2;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [STEP_W-1:0]      step_q;
  logic [SUM_W-1:0]       quo_q;
  logic [FRM_W-1:0]       rem_q;
  logic [ROOT_W-1:0]      root_q;
  logic [ROOT_W:0]        srem_q;
  logic [POS_W-1:0]       ch_q;
  logic                   last_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] rms_q;
  logic [POS_W-1:0]       out_ch_q;
  logic                   out_last_q;

  logic [FRM_W:0]         rem_sh, rem_nx;
  logic                   div_ge;
  logic [ROOT_W+2:0]      srem_sh, trial, srem_nx;
  logic                   sq_ge;
  logic                   out_load;

  assign q_pop_o         = (state_q == ST_IDLE) && !q_empty_i;
  assign empty_o         = !out_valid_q;
  assign rms_value_o     = rms_q;
  assign channel_index_o = out_ch_q;
  assign last_of_block_o = out_last_q;

  // Load the result register once it is free or being popped.
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || pop_i);

  // Divide step: bring down the next dividend bit.
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign div_ge = (rem_sh >= {1'b0, nfr_i});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, nfr_i}) : rem_sh;

  // Root step: bring down the next two radicand bits.
  assign srem_sh = {srem_q, quo_q[SUM_W-1 -: 2]};
  assign trial   = (ROOT_W+3)'({root_q, 2'b01});
  assign sq_ge   = (srem_sh >= trial);
  assign srem_nx = sq_ge ? (srem_sh - trial) : srem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      srem_q      <= '0;
      ch_q        <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rms_q       <= '0;
      out_ch_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            {quo_q, ch_q, last_q} <= q_data_i;
            rem_q   <= '0;
            step_q  <= STEP_W'(SUM_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q <= {quo_q[SUM_W-2:0], div_ge};
          rem_q <= rem_nx[FRM_W-1:0];
          if (step_q == '0) begin
            root_q  <= '0;
            srem_q  <= '0;
            step_q  <= STEP_W'(ROOT_W - 1);
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          quo_q  <= quo_q << 2;
          root_q <= {root_q[ROOT_W-2:0], sq_ge};
          srem_q <= srem_nx[ROOT_W:0];
          if (step_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (out_load) begin
            rms_q      <= root_q[SAMPLE_BITS-1:0];
            out_ch_q   <= ch_q;
            out_last_q <= last_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_take_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_DIV && step_q == STEP_W'(SUM_W - 1)))
    else $error("queue beat did not start the divide");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || pop_i)) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not loaded into output register");

endmodule

[design/multichannel_block_rms_top.sv]
// ----------------------------------------------------------------------------
// multichannel_block_rms_top: per-channel RMS over blocks of interleaved samples
// Squares and accumulates each sample per channel; after a full block emits
// floor(sqrt(floor(sum / frames))) for each channel in channel order.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------
//   samples  | in        | push_i / full_o         | sample_i
//   results  | out       | pop_i / empty_o         | rms_value_o, channel_index_o,
//            |           |                         | last_of_block_o
//   config   | in        | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One sample a cycle is taken mid-block; the sample pipeline is two stages.
// At block end intake holds for the drain of the channel sums into a two-entry
// queue, one beat a cycle, and further while that queue is full.
// In the back end each result goes through taking the beat, 48 divide steps,
// 24 root steps and the load of the result register, one result at a time;
// intake resumes once the last sum is queued, while the back still works off
// up to three results.
// Reset (rst_ni, async) clears sums, positions and registers; no
// clearing pass is needed. A stalled pop holds the result register.
// ----------------------------------------------------------------------------
module multichannel_block_rms_top #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_FRAMES   = 65536,
  parameter int unsigned SAMPLE_BITS  = 16,
  localparam int unsigned POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic [SAMPLE_BITS-1:0]               rms_value_o,
  output logic [POS_W-1:0]                     channel_index_o,
  output logic                                 last_of_block_o,
  input  logic                                 cfg_we_i,
  input  logic [mbrms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mbrms_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CH_W      = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned FRM_W     = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CH_CFG_W  = mbrms_pkg::CH_CFG_W;
  localparam int unsigned FRM_CFG_W = mbrms_pkg::FRM_CFG_W;
  localparam int unsigned CMP_CW    = ((CH_W > CH_CFG_W) ? CH_W : CH_CFG_W) + 1;
  localparam int unsigned CMP_FW    = ((FRM_W > FRM_CFG_W) ? FRM_W : FRM_CFG_W) + 1;
  localparam int unsigned ITEM_W    = mbrms_pkg::SUM_W + POS_W + 1;

  logic [CH_CFG_W-1:0]  ch_cfg_q;
  logic [FRM_CFG_W-1:0] frm_cfg_q;
  logic [CH_W-1:0]      nch;
  logic [FRM_W-1:0]     nfr;

  logic                 q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_cfg_q  <= mbrms_pkg::CH_CFG_RESET;
      frm_cfg_q <= mbrms_pkg::FRM_CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (mbrms_pkg::cfg_reg_e'(cfg_idx_i))
        mbrms_pkg::REG_CHANNEL_COUNT:    ch_cfg_q  <= cfg_data_i[CH_CFG_W-1:0];
        mbrms_pkg::REG_FRAMES_PER_BLOCK: frm_cfg_q <= cfg_data_i[FRM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero reads as one, large values clamp to the maximum.
  always_comb begin
    if (ch_cfg_q == '0) begin
      nch = CH_W'(1);
    end else if (CMP_CW'(ch_cfg_q) > CMP_CW'(MAX_CHANNELS)) begin
      nch = CH_W'(MAX_CHANNELS);
    end else begin
      nch = CH_W'(ch_cfg_q);
    end
  end

  always_comb begin
    if (frm_cfg_q == '0) begin
      nfr = FRM_W'(1);
    end else if (CMP_FW'(frm_cfg_q) > CMP_FW'(MAX_FRAMES)) begin
      nfr = FRM_W'(MAX_FRAMES);
    end else begin
      nfr = FRM_W'(frm_cfg_q);
    end
  end

  mbrms_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .sample_i (sample_i),
    .full_o   (full_o),
    .nch_i    (nch),
    .nfr_i    (nfr),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  mbrms_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (mbrms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  mbrms_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_data_i        (q_rdata),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .nfr_i           (nfr),
    .rms_value_o     (rms_value_o),
    .channel_index_o (channel_index_o),
    .last_of_block_o (last_of_block_o),
    .empty_o         (empty_o),
    .pop_i           (pop_i)
  );

endmodule
